// File: rtl/core/ssd_pkg.sv
`timescale 1ns / 1ps
// ssd_pkg: types, constants and the crc byte step shared by the status packet deframer
// no dependencies

package ssd_pkg;

   localparam int unsigned MAX_FRAME_BYTES_DEF = 128;

   localparam logic [7:0]  HDR_FF       = 8'hFF;
   localparam logic [7:0]  HDR_FD       = 8'hFD;
   localparam logic [7:0]  STUFF_BYTE   = 8'hFD;
   localparam logic [7:0]  STATUS_INSTR = 8'h55;
   localparam logic [23:0] STUFF_RUN    = 24'hFFFFFD;
   localparam logic [15:0] CRC_POLY     = 16'h8005;
   localparam logic [15:0] MIN_LEN      = 16'd4;
   localparam logic [1:0]  WIN_FULL     = 2'd3;

   typedef enum logic [3:0] {
      PH_HUNT0 = 4'd0,
      PH_HUNT1 = 4'd1,
      PH_HUNT2 = 4'd2,
      PH_RSV   = 4'd3,
      PH_ID    = 4'd4,
      PH_LENL  = 4'd5,
      PH_LENH  = 4'd6,
      PH_INSTR = 4'd7,
      PH_ERR   = 4'd8,
      PH_PARAM = 4'd9,
      PH_STUFF = 4'd10,
      PH_CRCL  = 4'd11,
      PH_CRCH  = 4'd12
   } phase_type;

   typedef enum logic [2:0] {
      KIND_PARAM  = 3'd0,
      KIND_GOOD   = 3'd1,
      KIND_BADCRC = 3'd2,
      KIND_STUFF  = 3'd3,
      KIND_FRAME  = 3'd4
   } kind_type;

   typedef struct packed {
      logic       valid;
      kind_type   kind;
      logic [7:0] data;
      logic [7:0] id;
      logic [7:0] err;
      logic [7:0] count;
   } result_type;

   // crc-16, msb first, one byte per call
   function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
         c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
      end
      return c;
   endfunction

   localparam logic [15:0] CRC_HEADER =
      crc_step(crc_step(crc_step(16'h0000, HDR_FF), HDR_FF), HDR_FD);

endpackage

// File: rtl/core/servo_status_packet_deframer_unit.sv
`timescale 1ns / 1ps
// servo_status_packet_deframer_unit: top level of the servo status packet deframer
// depends on ssd_pkg, ssd_input_stage, ssd_frame_fsm, ssd_result_stage

// Takes one received serial byte per request and reports parameter bytes and packet
// outcomes (good, crc mismatch, stuffing error, frame error) on the response channel.
// A byte can be accepted every clock cycle while the response is not stalled. An
// accepted byte lands in an input register and is parsed once the output register can
// take a result; any result is then captured in the output register. The rate is set
// by the combinational parse between those two registers, whose longest path is the
// eight-step crc-16 byte update. A stalled response holds the parser, and the input
// register then stalls further requests. MAX_FRAME_BYTES bounds 7 plus the length
// field; longer frames are reported as frame errors.

module servo_status_packet_deframer_unit #(
   parameter int unsigned MAX_FRAME_BYTES = ssd_pkg::MAX_FRAME_BYTES_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [2:0] rsp_result_kind,
   output logic [7:0] rsp_data_byte,
   output logic [7:0] rsp_device_id,
   output logic [7:0] rsp_status_error,
   output logic [7:0] rsp_param_count
);

   import ssd_pkg::*;

   logic       hold_valid;
   logic [7:0] hold_byte;
   logic       out_ready;
   logic       step;
   result_type res;

   assign step = hold_valid && out_ready;

   ssd_input_stage u_input (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_rx_byte (req_rx_byte),
      .take        (step),
      .hold_valid  (hold_valid),
      .hold_byte   (hold_byte)
   );

   ssd_frame_fsm #(
      .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
   ) u_fsm (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .rx_byte (hold_byte),
      .res     (res)
   );

   ssd_result_stage u_result (
      .clock            (clock),
      .reset            (reset),
      .load             (step),
      .res              (res),
      .ready            (out_ready),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_result_kind  (rsp_result_kind),
      .rsp_data_byte    (rsp_data_byte),
      .rsp_device_id    (rsp_device_id),
      .rsp_status_error (rsp_status_error),
      .rsp_param_count  (rsp_param_count)
   );

endmodule

// File: rtl/core/ssd_input_stage.sv
`timescale 1ns / 1ps
// ssd_input_stage: input register holding one received byte for the frame logic
// no dependencies

module ssd_input_stage (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_byte,
   input  logic       take,
   output logic       hold_valid,
   output logic [7:0] hold_byte
);

   logic       valid_ff;
   logic       valid_in;
   logic [7:0] byte_ff;
   logic       accept;

   assign req_stall  = valid_ff && !take;
   assign accept     = req_valid && !req_stall;
   assign valid_in   = accept || (valid_ff && !take);
   assign hold_valid = valid_ff;
   assign hold_byte  = byte_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         byte_ff <= req_rx_byte;
      end
   end

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> valid_ff)
      else $error("request stalled with an empty input register");

endmodule

// File: rtl/core/ssd_frame_fsm.sv
`timescale 1ns / 1ps
// ssd_frame_fsm: packet phase tracking, crc, unstuffing and result forming
// depends on ssd_pkg (phase_type, kind_type, result_type, crc_step)

module ssd_frame_fsm #(
   parameter int unsigned MAX_FRAME_BYTES = ssd_pkg::MAX_FRAME_BYTES_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  logic [7:0]          rx_byte,
   output ssd_pkg::result_type res
);

   import ssd_pkg::*;

   localparam int unsigned LEFT_W  = $clog2(MAX_FRAME_BYTES - 6);
   localparam logic [16:0] MAX_LEN = 17'(MAX_FRAME_BYTES - 7);

   phase_type         phase_ff, phase_in;
   logic [LEFT_W-1:0] left_ff, left_in;
   logic [15:0]       crc_ff, crc_in;
   logic [23:0]       win_ff, win_in;
   logic [1:0]        fill_ff, fill_in;
   logic [7:0]        id_ff, id_in;
   logic [7:0]        err_ff, err_in;
   logic [7:0]        count_ff, count_in;
   logic [7:0]        crc_lo_ff, crc_lo_in;
   logic [7:0]        len_lo_ff, len_lo_in;

   logic [15:0]       crc_next;
   logic [15:0]       len_full;
   logic              len_bad;
   logic [LEFT_W-1:0] left_dec;
   logic              last_body;
   logic [23:0]       win_push;
   logic [1:0]        fill_push;
   logic              hit;
   logic              stuff_bad;
   logic [7:0]        count_inc;

   assign crc_next  = crc_step(crc_ff, rx_byte);
   assign len_full  = {rx_byte, len_lo_ff};
   assign len_bad   = (len_full < MIN_LEN) || ({1'b0, len_full} > MAX_LEN);
   assign left_dec  = left_ff - LEFT_W'(1);
   // only the two crc bytes remain after this one
   assign last_body = (left_dec == LEFT_W'(2));
   assign win_push  = {win_ff[15:0], rx_byte};
   assign fill_push = (fill_ff == WIN_FULL) ? WIN_FULL : fill_ff + 2'd1;
   assign hit       = (fill_push == WIN_FULL) && (win_push == STUFF_RUN);
   assign stuff_bad = (left_ff <= LEFT_W'(2)) || (rx_byte != STUFF_BYTE);
   assign count_inc = (count_ff == 8'hFF) ? count_ff : count_ff + 8'd1;

   // next phase
   always_comb begin
      phase_in = phase_ff;
      unique case (phase_ff)
         PH_HUNT0: phase_in = (rx_byte == HDR_FF) ? PH_HUNT1 : PH_HUNT0;
         PH_HUNT1: phase_in = (rx_byte == HDR_FF) ? PH_HUNT2 : PH_HUNT0;
         PH_HUNT2: begin
            if (rx_byte == HDR_FD) begin
               phase_in = PH_RSV;
            end else if (rx_byte != HDR_FF) begin
               phase_in = PH_HUNT0;
            end
         end
         PH_RSV:   phase_in = (rx_byte == STUFF_BYTE) ? PH_HUNT0 : PH_ID;
         PH_ID:    phase_in = (rx_byte == HDR_FF || rx_byte == HDR_FD) ? PH_HUNT0 : PH_LENL;
         PH_LENL:  phase_in = PH_LENH;
         PH_LENH:  phase_in = len_bad ? PH_HUNT0 : PH_INSTR;
         PH_INSTR: phase_in = (rx_byte != STATUS_INSTR) ? PH_HUNT0 : PH_ERR;
         PH_ERR:   phase_in = last_body ? PH_CRCL : PH_PARAM;
         PH_PARAM: begin
            if (hit) begin
               phase_in = PH_STUFF;
            end else begin
               phase_in = last_body ? PH_CRCL : PH_PARAM;
            end
         end
         PH_STUFF: begin
            if (stuff_bad) begin
               phase_in = PH_HUNT0;
            end else begin
               phase_in = last_body ? PH_CRCL : PH_PARAM;
            end
         end
         PH_CRCL:  phase_in = PH_CRCH;
         PH_CRCH:  phase_in = PH_HUNT0;
         default:  phase_in = PH_HUNT0;
      endcase
   end

   // datapath updates and result
   always_comb begin
      crc_in    = crc_ff;
      left_in   = left_ff;
      win_in    = win_ff;
      fill_in   = fill_ff;
      id_in     = id_ff;
      err_in    = err_ff;
      count_in  = count_ff;
      crc_lo_in = crc_lo_ff;
      len_lo_in = len_lo_ff;
      res.valid = 1'b0;
      res.kind  = KIND_PARAM;
      res.data  = 8'h00;
      res.id    = id_ff;
      res.err   = err_ff;
      res.count = count_ff;
      unique case (phase_ff)
         PH_HUNT2: begin
            if (rx_byte == HDR_FD) begin
               crc_in   = CRC_HEADER;
               id_in    = 8'h00;
               err_in   = 8'h00;
               count_in = 8'h00;
               win_in   = 24'h000000;
               fill_in  = 2'd0;
            end
         end
         PH_RSV: begin
            if (rx_byte == STUFF_BYTE) begin
               res.valid = 1'b1;
               res.kind  = KIND_FRAME;
            end else begin
               crc_in = crc_next;
            end
         end
         PH_ID: begin
            if (rx_byte == HDR_FF || rx_byte == HDR_FD) begin
               res.valid = 1'b1;
               res.kind  = KIND_FRAME;
            end else begin
               crc_in = crc_next;
               id_in  = rx_byte;
            end
         end
         PH_LENL: begin
            crc_in    = crc_next;
            len_lo_in = rx_byte;
         end
         PH_LENH: begin
            if (len_bad) begin
               res.valid = 1'b1;
               res.kind  = KIND_FRAME;
            end else begin
               crc_in  = crc_next;
               left_in = len_full[LEFT_W-1:0];
            end
         end
         PH_INSTR: begin
            if (rx_byte != STATUS_INSTR) begin
               res.valid = 1'b1;
               res.kind  = KIND_FRAME;
            end else begin
               crc_in  = crc_next;
               win_in  = win_push;
               fill_in = fill_push;
               left_in = left_dec;
            end
         end
         PH_ERR: begin
            crc_in  = crc_next;
            win_in  = win_push;
            fill_in = fill_push;
            err_in  = rx_byte;
            left_in = left_dec;
         end
         PH_PARAM: begin
            crc_in    = crc_next;
            win_in    = win_push;
            fill_in   = fill_push;
            left_in   = left_dec;
            count_in  = count_inc;
            res.valid = 1'b1;
            res.kind  = KIND_PARAM;
            res.data  = rx_byte;
            res.count = count_inc;
         end
         PH_STUFF: begin
            if (stuff_bad) begin
               res.valid = 1'b1;
               res.kind  = KIND_STUFF;
            end else begin
               crc_in  = crc_next;
               left_in = left_dec;
               win_in  = 24'h000000;
               fill_in = 2'd0;
            end
         end
         PH_CRCL: begin
            crc_lo_in = rx_byte;
         end
         PH_CRCH: begin
            res.valid = 1'b1;
            res.kind  = ({rx_byte, crc_lo_ff} == crc_ff) ? KIND_GOOD : KIND_BADCRC;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT0;
      end else if (step) begin
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         crc_ff    <= crc_in;
         left_ff   <= left_in;
         win_ff    <= win_in;
         fill_ff   <= fill_in;
         id_ff     <= id_in;
         err_ff    <= err_in;
         count_ff  <= count_in;
         crc_lo_ff <= crc_lo_in;
         len_lo_ff <= len_lo_in;
      end
   end

   a_close_resyncs: assert property (@(posedge clock) disable iff (reset)
      step && res.valid && res.kind != KIND_PARAM |=> phase_ff == PH_HUNT0)
      else $error("closing or error result without return to hunting");

   a_param_has_room: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_PARAM |-> left_ff > LEFT_W'(2))
      else $error("parameter phase with no room left before the crc");

   a_hunt_silent: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_HUNT0 || phase_ff == PH_HUNT1 || phase_ff == PH_HUNT2) |-> !res.valid)
      else $error("result produced while hunting for a header");

endmodule

// File: rtl/core/ssd_result_stage.sv
`timescale 1ns / 1ps
// ssd_result_stage: output register for one result, with its valid/stall handshake
// depends on ssd_pkg (result_type, kind_type)

module ssd_result_stage (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  ssd_pkg::result_type res,
   output logic                ready,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [2:0]          rsp_result_kind,
   output logic [7:0]          rsp_data_byte,
   output logic [7:0]          rsp_device_id,
   output logic [7:0]          rsp_status_error,
   output logic [7:0]          rsp_param_count
);

   import ssd_pkg::*;

   logic       valid_ff;
   logic       valid_in;
   logic       take;
   result_type res_ff;

   // free once the held result leaves or when nothing is held
   assign ready    = !valid_ff || !rsp_stall;
   assign take     = load && res.valid;
   assign valid_in = take || (valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         res_ff <= res;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_result_kind  = res_ff.kind;
   assign rsp_data_byte    = res_ff.data;
   assign rsp_device_id    = res_ff.id;
   assign rsp_status_error = res_ff.err;
   assign rsp_param_count  = res_ff.count;

endmodule
